[rtl/mnt_pkg.sv]
// Shared constants, codes and the note saturation function for the MIDI note transposer.
// Used by the top level and by the assertion checker; depends on nothing.
package mnt_pkg;

    localparam int CHANNELS    = 16;
    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int COUNT_CAP   = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W     = (COUNT_CAP > 1) ? $clog2(COUNT_CAP) : 1;
    localparam int TBL_DEPTH = CHANNELS * SLOTS;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 56;

    localparam logic [1:0] CMD_MSG   = 2'd0;
    localparam logic [1:0] CMD_SLOT  = 2'd1;
    localparam logic [1:0] CMD_COUNT = 2'd2;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

    localparam logic [6:0] NOTE_MIN = 7'd1;
    localparam logic [6:0] NOTE_MAX = 7'd127;

    localparam logic [4:0] COUNT_LIMIT = 5'(COUNT_CAP);

    // Adds a signed offset to a note and clamps the sum to the range 1 to 127.
    function automatic logic [6:0] sat_note(input logic [6:0] note,
                                            input logic [7:0] offset);
        logic signed [9:0] sum;
        sum = $signed({3'b000, note}) + $signed({{2{offset[7]}}, offset});
        if (sum < $signed({3'b000, NOTE_MIN})) begin
            return NOTE_MIN;
        end else if (sum > $signed({3'b000, NOTE_MAX})) begin
            return NOTE_MAX;
        end else begin
            return sum[6:0];
        end
    endfunction

endpackage

[rtl/mnt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the transposition table; depends on nothing.
module mnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/midi_note_transposer.sv]
// A load item is taken while idle and gives no result; a pass-through message is
// registered into the output from the pass state; a transposed note goes through the
// fetch state (the registered table read) and its copies then leave from the emit state,
// one copy per cycle unless the output stalls, all built by the single saturating adder.
// A new item is taken only in idle, so the block is through with one item before the next.
// Reset (synchronous, active low) clears all channel counts, the sequencer state and the output valid.
module midi_note_transposer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: event_time, status_byte, data_one, data_two, target_channel,
    //        target_slot, shift_amount, slot_total, zero padding
    input  logic [mnt_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // tuser: command
    input  logic [1:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: out_time, out_status, out_data_one, out_data_two, zero padding
    output logic [mnt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_PASS  = 2'd3;

    // Input fields.
    logic [31:0] in_time;
    logic [7:0]  in_status;
    logic [6:0]  in_d1;
    logic [6:0]  in_d2;
    logic [3:0]  in_tch;
    logic [3:0]  in_tsl;
    logic [7:0]  in_shift;
    logic [4:0]  in_tot;

    assign in_time   = i_s_tdata[31:0];
    assign in_status = i_s_tdata[39:32];
    assign in_d1     = i_s_tdata[46:40];
    assign in_d2     = i_s_tdata[53:47];
    assign in_tch    = i_s_tdata[57:54];
    assign in_tsl    = i_s_tdata[61:58];
    assign in_shift  = i_s_tdata[69:62];
    assign in_tot    = i_s_tdata[74:70];

    logic [1:0]                   r_state, n_state;
    logic [mnt_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [4:0]                   r_cnt, n_cnt;
    logic [mnt_pkg::TBL_AW-1:0]   r_base, n_base;
    logic [31:0]                  r_time;
    logic [7:0]                   r_status;
    logic [6:0]                   r_d1;
    logic [6:0]                   r_d2;
    logic [4:0]                   r_count [mnt_pkg::CHANNELS];

    logic        r_m_tvalid;
    logic [31:0] r_m_time;
    logic [7:0]  r_m_status;
    logic [6:0]  r_m_d1;
    logic [6:0]  r_m_d2;
    logic        r_m_last;

    logic                          accept;
    logic                          can_load;
    logic                          tch_ok;
    logic                          tsl_ok;
    logic                          note_ch_ok;
    logic                          is_note;
    logic [4:0]                    ch_count;
    logic                          run_notes;
    logic [4:0]                    clamped_tot;
    logic                          ram_we;
    logic [mnt_pkg::TBL_AW-1:0]    ram_waddr;
    logic [mnt_pkg::TBL_AW-1:0]    ram_raddr;
    logic [mnt_pkg::TBL_AW-1:0]    note_base;
    logic [7:0]                    ram_rdata;
    logic                          emit_fire;
    logic                          pass_fire;
    logic                          last_copy;
    logic [mnt_pkg::IDX_W-1:0]     idx_next;
    logic [6:0]                    sat_d1;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign can_load   = !r_m_tvalid || i_m_tready;

    assign tch_ok     = ({1'b0, in_tch} < 5'(mnt_pkg::CHANNELS));
    assign tsl_ok     = ({3'b000, in_tsl} < 7'(mnt_pkg::SLOTS));
    assign note_ch_ok = ({1'b0, in_status[3:0]} < 5'(mnt_pkg::CHANNELS));
    assign is_note    = (in_status[7:4] == mnt_pkg::KIND_NOTE_ON) ||
                        (in_status[7:4] == mnt_pkg::KIND_NOTE_OFF);
    assign ch_count   = note_ch_ok ? r_count[in_status[mnt_pkg::CH_W-1:0]] : 5'd0;
    assign run_notes  = is_note && (ch_count != 5'd0);
    assign clamped_tot = (in_tot > mnt_pkg::COUNT_LIMIT) ? mnt_pkg::COUNT_LIMIT : in_tot;

    assign ram_we    = accept && (i_s_tuser == mnt_pkg::CMD_SLOT) && tch_ok && tsl_ok;
    assign ram_waddr = mnt_pkg::TBL_AW'(in_tch[mnt_pkg::CH_W-1:0] * mnt_pkg::SLOTS)
                       + mnt_pkg::TBL_AW'(in_tsl);
    assign note_base = mnt_pkg::TBL_AW'(in_status[mnt_pkg::CH_W-1:0] * mnt_pkg::SLOTS);

    assign emit_fire = (r_state == ST_EMIT) && can_load;
    assign pass_fire = (r_state == ST_PASS) && can_load;
    assign last_copy = ((5'(r_idx) + 5'd1) == r_cnt);

    // The read address moves to the next slot whenever a copy other than the last leaves,
    // so the registered read data always belongs to the copy about to be built.
    assign idx_next  = (emit_fire && !last_copy) ? r_idx + 1'b1 : r_idx;
    assign ram_raddr = r_base + mnt_pkg::TBL_AW'(idx_next);

    assign sat_d1 = mnt_pkg::sat_note(r_d1, ram_rdata);

    mnt_ram #(
        .WIDTH (8),
        .DEPTH (mnt_pkg::TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_shift),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = idx_next;
        n_cnt   = r_cnt;
        n_base  = r_base;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_s_tuser == mnt_pkg::CMD_MSG)) begin
                    n_idx  = '0;
                    n_cnt  = ch_count;
                    n_base = note_base;
                    n_state = run_notes ? ST_FETCH : ST_PASS;
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_fire && last_copy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PASS: begin
                if (pass_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
            for (int i = 0; i < mnt_pkg::CHANNELS; i++) begin
                r_count[i] <= 5'd0;
            end
        end else begin
            r_state <= n_state;
            if (emit_fire || pass_fire) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            if (accept && (i_s_tuser == mnt_pkg::CMD_COUNT) && tch_ok) begin
                r_count[in_tch[mnt_pkg::CH_W-1:0]] <= clamped_tot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_base <= n_base;
        if (accept) begin
            r_time   <= in_time;
            r_status <= in_status;
            r_d1     <= in_d1;
            r_d2     <= in_d2;
        end
        if (emit_fire || pass_fire) begin
            r_m_time   <= r_time;
            r_m_status <= r_status;
            r_m_d1     <= emit_fire ? sat_d1 : r_d1;
            r_m_d2     <= r_d2;
            r_m_last   <= pass_fire || last_copy;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {2'b00, r_m_d2, r_m_d1, r_m_status, r_m_time};
    assign o_m_tlast  = r_m_last;

endmodule

[rtl/mnt_checker.sv]
// Port-level assertions for the MIDI note transposer, bound to the top level.
// Depends on mnt_pkg for the stream widths.
module mnt_port_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [mnt_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input logic [1:0]                       i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mnt_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic                             o_m_tlast
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // No new item is taken while a run of copies is still open.
    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input ready during an open run");

    // Copies of one note leave back to back.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside a run of copies");

    // Every copy of a run carries the same time, status and velocity.
    a_run_fields_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            (o_m_tdata[39:0] == $past(o_m_tdata[39:0])) &&
            (o_m_tdata[53:47] == $past(o_m_tdata[53:47])))
        else $error("copy fields differ within a run");

endmodule

bind midi_note_transposer mnt_port_checker u_mnt_checker (.*);
